/* sv/vefe_pkg.sv */
// Shared types, constants and helper functions of the voxel face extractor.
// Used by every module of the block; depends on nothing.
`default_nettype none

package vefe_pkg;

	localparam int MAX_DIM  = 32;
	localparam int CDIM     = MAX_DIM + 1;
	localparam int NCELLS   = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int NCORNERS = CDIM * CDIM * CDIM;

	// Address widths of the cell store and the corner stores.
	localparam int CAW = $clog2(NCELLS);
	localparam int KW  = $clog2(NCORNERS);
	// Vertex index width, dimension register width, corner coordinate width.
	localparam int VW  = 16;
	localparam int DW  = $clog2(MAX_DIM + 1);
	localparam int CW  = $clog2(CDIM);
	// Configuration port address width.
	localparam int PAW = 4;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_EXTRACT = 2'd1,
		ACT_START   = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_DIM_X = 2'd0,
		REG_DIM_Y = 2'd1,
		REG_DIM_Z = 2'd2,
		REG_NONE  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		SIDE_NX = 3'd0,
		SIDE_PX = 3'd1,
		SIDE_NY = 3'd2,
		SIDE_PY = 3'd3,
		SIDE_NZ = 3'd4,
		SIDE_PZ = 3'd5
	} side_t;

	typedef struct packed {
		logic [1:0] action;
		logic [4:0] cell_x;
		logic [4:0] cell_y;
		logic [4:0] cell_z;
		logic       cell_occupied;
	} item_t;

	typedef struct packed {
		logic [4:0]    face_x;
		logic [4:0]    face_y;
		logic [4:0]    face_z;
		logic [2:0]    face_side;
		logic [VW-1:0] vertex_a;
		logic [VW-1:0] vertex_b;
		logic [VW-1:0] vertex_c;
		logic [VW-1:0] vertex_d;
		logic [3:0]    new_corners;
		logic          last_face;
	} face_t;

	// Write request into the corner stores: map[k] = v and back link rev[v] = k.
	typedef struct packed {
		logic          en;
		logic [KW-1:0] k;
		logic [VW-1:0] v;
	} vtx_wr_t;

	// Clamp a written dimension into the legal range.
	function automatic logic [DW-1:0] clamp_dim(input logic [5:0] v);
		logic [DW-1:0] r;
		if (v < 6'd2) begin
			r = DW'(2);
		end else if (32'(v) > MAX_DIM) begin
			r = DW'(MAX_DIM);
		end else begin
			r = DW'(v);
		end
		return r;
	endfunction

	// Corner offset {ox, oy, oz} of corner c of side s, in winding order.
	function automatic logic [2:0] corner_off(input logic [2:0] s, input logic [1:0] c);
		logic [2:0] r;
		case ({s, c})
			5'b000_00: r = 3'b000;
			5'b000_01: r = 3'b001;
			5'b000_10: r = 3'b011;
			5'b000_11: r = 3'b010;
			5'b001_00: r = 3'b100;
			5'b001_01: r = 3'b110;
			5'b001_10: r = 3'b111;
			5'b001_11: r = 3'b101;
			5'b010_00: r = 3'b000;
			5'b010_01: r = 3'b100;
			5'b010_10: r = 3'b101;
			5'b010_11: r = 3'b001;
			5'b011_00: r = 3'b010;
			5'b011_01: r = 3'b011;
			5'b011_10: r = 3'b111;
			5'b011_11: r = 3'b110;
			5'b100_00: r = 3'b000;
			5'b100_01: r = 3'b010;
			5'b100_10: r = 3'b110;
			5'b100_11: r = 3'b100;
			5'b101_00: r = 3'b001;
			5'b101_01: r = 3'b101;
			5'b101_10: r = 3'b111;
			5'b101_11: r = 3'b011;
			default:   r = 3'b000;
		endcase
		return r;
	endfunction

	// Linear corner index at a stride of CDIM per axis.
	function automatic logic [KW-1:0] corner_index(input logic [CW-1:0] cx,
			input logic [CW-1:0] cy, input logic [CW-1:0] cz);
		return KW'((32'(cz) * CDIM + 32'(cy)) * CDIM + 32'(cx));
	endfunction

	// Linear cell index at a stride of MAX_DIM per axis.
	function automatic logic [CAW-1:0] cell_index(input logic [4:0] x,
			input logic [4:0] y, input logic [4:0] z);
		return CAW'((32'(z) * MAX_DIM + 32'(y)) * MAX_DIM + 32'(x));
	endfunction

endpackage

`default_nettype wire

/* sv/voxel_exposed_face_extractor_unit.sv */
// Top level of the voxel face extractor: config registers, sequencer, output register.
// Depends on vefe_pkg, vefe_occ_mem and vefe_vtx_mem.
//
//   channel | signals                       | direction | carries
//   config  | psel penable pwrite paddr ... | in / out  | dim_x, dim_y, dim_z
//   item    | item_valid item_stall item    | in        | load, extract, start
//   face    | face_valid face_stall face    | out       | one exposed face each
//
// Load, start and unused requests are taken in the idle state, as is an extract request
// for a cell outside the grid. An extract request reads its cell, where an empty cell
// ends, then its six neighbors one after another; then one select step per side plus one
// to finish, and per exposed face three steps per corner (map, back link, check) and one
// to hand it over. A new request is taken only back in idle; the single memory ports set that.
// Reset clears the counter and control; no clearing pass is needed.
// A stalled face holds the sequencer once the next face is ready.
`default_nettype none

module voxel_exposed_face_extractor_unit
	import vefe_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [PAW-1:0]  paddr,
	input  wire logic [31:0]     pwdata,
	output logic      [31:0]     prdata,
	output logic                 pready,
	input  wire logic            item_valid,
	output logic                 item_stall,
	input  wire item_t           item,
	output logic                 face_valid,
	input  wire logic            face_stall,
	output face_t                face
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_CEN_RD = 10'b00_0000_0010,
		ST_CEN_WT = 10'b00_0000_0100,
		ST_NB_RD  = 10'b00_0000_1000,
		ST_NB_WT  = 10'b00_0001_0000,
		ST_SEL    = 10'b00_0010_0000,
		ST_C_RD   = 10'b00_0100_0000,
		ST_C_RV   = 10'b00_1000_0000,
		ST_C_CK   = 10'b01_0000_0000,
		ST_EMIT   = 10'b10_0000_0000
	} state_t;

	state_t          state_q;
	logic [DW-1:0]   dim_x_q, dim_y_q, dim_z_q;
	logic [4:0]      x_q, y_q, z_q;
	logic [2:0]      side_q;
	logic [1:0]      corner_q;
	logic [5:0]      exposed_q;
	logic            nb_out_q;
	logic [VW-1:0]   verts_q [4];
	logic [3:0]      fresh_q;
	logic [VW-1:0]   nv_q;
	logic [VW-1:0]   v_q;
	logic [KW-1:0]   k_q;

	logic            accept;
	logic            wr_cfg;
	reg_idx_t        reg_idx;
	logic            in_grid;
	logic            occ_we;
	logic [CAW-1:0]  occ_raddr;
	logic            occ_rdata;
	logic [4:0]      nx, ny, nz;
	logic            nb_out;
	logic [2:0]      off;
	logic [KW-1:0]   k_c;
	logic [VW-1:0]   map_rdata;
	logic [KW-1:0]   rev_rdata;
	logic            hit;
	vtx_wr_t         vwr;
	logic            out_free;
	logic            later;

	assign pready     = 1'b1;
	assign reg_idx    = reg_idx_t'(paddr[3:2]);
	assign wr_cfg     = psel && penable && pwrite;
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q <= clamp_dim(6'd32);
			dim_y_q <= clamp_dim(6'd32);
			dim_z_q <= clamp_dim(6'd32);
		end else if (wr_cfg) begin
			case (reg_idx)
				REG_DIM_X: dim_x_q <= clamp_dim(pwdata[5:0]);
				REG_DIM_Y: dim_y_q <= clamp_dim(pwdata[5:0]);
				REG_DIM_Z: dim_z_q <= clamp_dim(pwdata[5:0]);
				default:   ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (reg_idx)
			REG_DIM_X: prdata = 32'(dim_x_q);
			REG_DIM_Y: prdata = 32'(dim_y_q);
			REG_DIM_Z: prdata = 32'(dim_z_q);
			default:   prdata = 32'd0;
		endcase
	end

	// Whether the cell named by the request lies in the grid.
	assign in_grid = ((DW+1)'(item.cell_x) < (DW+1)'(dim_x_q)) &&
		((DW+1)'(item.cell_y) < (DW+1)'(dim_y_q)) &&
		((DW+1)'(item.cell_z) < (DW+1)'(dim_z_q));
	assign occ_we = accept && (action_t'(item.action) == ACT_LOAD) && in_grid;

	// Neighbor of the current side and whether it leaves the grid.
	always_comb begin
		nx = x_q;
		ny = y_q;
		nz = z_q;
		case (side_q)
			SIDE_NX: begin
				nx     = x_q - 5'd1;
				nb_out = (x_q == 5'd0);
			end
			SIDE_PX: begin
				nx     = x_q + 5'd1;
				nb_out = ((DW+1)'(x_q) + 1'b1) >= (DW+1)'(dim_x_q);
			end
			SIDE_NY: begin
				ny     = y_q - 5'd1;
				nb_out = (y_q == 5'd0);
			end
			SIDE_PY: begin
				ny     = y_q + 5'd1;
				nb_out = ((DW+1)'(y_q) + 1'b1) >= (DW+1)'(dim_y_q);
			end
			SIDE_NZ: begin
				nz     = z_q - 5'd1;
				nb_out = (z_q == 5'd0);
			end
			SIDE_PZ: begin
				nz     = z_q + 5'd1;
				nb_out = ((DW+1)'(z_q) + 1'b1) >= (DW+1)'(dim_z_q);
			end
			default: nb_out = 1'b1;
		endcase
	end

	// Occupancy read address: the cell itself, then its neighbors.
	assign occ_raddr = (state_q == ST_CEN_RD) ? cell_index(x_q, y_q, z_q) :
		cell_index(nx, ny, nz);

	vefe_occ_mem u_occ (
		.clk   (clk),
		.we    (occ_we),
		.waddr (cell_index(item.cell_x, item.cell_y, item.cell_z)),
		.wdata (item.cell_occupied),
		.raddr (occ_raddr),
		.rdata (occ_rdata)
	);

	// Corner index of the current side and corner.
	assign off = corner_off(side_q, corner_q);
	assign k_c = corner_index(CW'(x_q) + CW'(off[2]), CW'(y_q) + CW'(off[1]),
		CW'(z_q) + CW'(off[0]));

	// A corner is known when its vertex is live and links back to it.
	assign hit     = (v_q < nv_q) && (rev_rdata == k_q);
	assign vwr.en  = (state_q == ST_C_CK) && !hit;
	assign vwr.k   = k_q;
	assign vwr.v   = nv_q;

	vefe_vtx_mem u_vtx (
		.clk       (clk),
		.wr        (vwr),
		.map_raddr (k_c),
		.map_rdata (map_rdata),
		.rev_raddr (map_rdata),
		.rev_rdata (rev_rdata)
	);

	// Any exposed side after the current one.
	always_comb begin
		later = 1'b0;
		for (int i = 0; i < 6; i++) begin
			if ((3'(i) > side_q) && exposed_q[i]) begin
				later = 1'b1;
			end
		end
	end

	assign out_free = !face_valid || !face_stall;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			nv_q      <= '0;
			side_q    <= '0;
			corner_q  <= '0;
			exposed_q <= '0;
			fresh_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						x_q <= item.cell_x;
						y_q <= item.cell_y;
						z_q <= item.cell_z;
						if (action_t'(item.action) == ACT_START) begin
							nv_q <= '0;
						end
						if ((action_t'(item.action) == ACT_EXTRACT) && in_grid) begin
							state_q <= ST_CEN_RD;
						end
					end
				end
				ST_CEN_RD: state_q <= ST_CEN_WT;
				ST_CEN_WT: begin
					side_q    <= '0;
					exposed_q <= '0;
					state_q   <= occ_rdata ? ST_NB_RD : ST_IDLE;
				end
				ST_NB_RD: begin
					nb_out_q <= nb_out;
					state_q  <= ST_NB_WT;
				end
				ST_NB_WT: begin
					exposed_q[side_q] <= nb_out_q || !occ_rdata;
					if (side_q == SIDE_PZ) begin
						side_q  <= '0;
						state_q <= ST_SEL;
					end else begin
						side_q  <= side_q + 3'd1;
						state_q <= ST_NB_RD;
					end
				end
				ST_SEL: begin
					if (side_q > SIDE_PZ) begin
						state_q <= ST_IDLE;
					end else if (exposed_q[side_q]) begin
						corner_q <= '0;
						fresh_q  <= '0;
						state_q  <= ST_C_RD;
					end else begin
						side_q <= side_q + 3'd1;
					end
				end
				ST_C_RD: begin
					k_q     <= k_c;
					state_q <= ST_C_RV;
				end
				ST_C_RV: begin
					v_q     <= map_rdata;
					state_q <= ST_C_CK;
				end
				ST_C_CK: begin
					verts_q[corner_q]  <= hit ? v_q : nv_q;
					fresh_q[corner_q]  <= !hit;
					if (!hit) begin
						nv_q <= nv_q + 1'b1;
					end
					if (corner_q == 2'd3) begin
						state_q <= ST_EMIT;
					end else begin
						corner_q <= corner_q + 2'd1;
						state_q  <= ST_C_RD;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						side_q  <= side_q + 3'd1;
						state_q <= ST_SEL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_valid <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			face_valid <= 1'b1;
		end else if (!face_stall) begin
			face_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			face.face_x      <= x_q;
			face.face_y      <= y_q;
			face.face_z      <= z_q;
			face.face_side   <= side_q;
			face.vertex_a    <= verts_q[0];
			face.vertex_b    <= verts_q[1];
			face.vertex_c    <= verts_q[2];
			face.vertex_d    <= verts_q[3];
			face.new_corners <= fresh_q;
			face.last_face   <= !later;
		end
	end

endmodule

`default_nettype wire

/* sv/vefe_occ_mem.sv */
// Occupancy bit store of the cell grid: one write port, one registered read port.
// Depends on vefe_pkg.
`default_nettype none

module vefe_occ_mem
	import vefe_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           we,
	input  wire logic [CAW-1:0] waddr,
	input  wire logic           wdata,
	input  wire logic [CAW-1:0] raddr,
	output logic                rdata
);

	logic mem [NCELLS];

	// Write and read both land at the clock edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* sv/vefe_vtx_mem.sv */
// Corner stores: corner to vertex map and the vertex to corner back link.
// A map entry is live when its vertex is below the counter and links back to it.
// Depends on vefe_pkg.
`default_nettype none

module vefe_vtx_mem
	import vefe_pkg::*;
(
	input  wire logic          clk,
	input  wire vtx_wr_t       wr,
	input  wire logic [KW-1:0] map_raddr,
	output logic [VW-1:0]      map_rdata,
	input  wire logic [VW-1:0] rev_raddr,
	output logic [KW-1:0]      rev_rdata
);

	// Stale map contents are harmless, since the back link check rejects them,
	// so the map may start from any value and is never cleared.
	bit   [VW-1:0] map_mem [NCORNERS];
	logic [KW-1:0] rev_mem [NCORNERS];

	// Corner to vertex map.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			map_mem[wr.k] <= wr.v;
		end
		map_rdata <= map_mem[map_raddr];
	end

	// Vertex to corner back link.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			rev_mem[KW'(wr.v)] <= wr.k;
		end
		rev_rdata <= rev_mem[KW'(rev_raddr)];
	end

endmodule

`default_nettype wire
